// File: rtl/assert_macros.svh
// Assertion macros shared by the text console writer RTL.
// Define NO_ASSERTIONS to compile every check out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies; imported by every module of the block.
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = CHAR_W + COLOR_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 4'd7;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE  = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_SPACE    = 8'd32;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CHAR,
        OP_NEWLINE,
        OP_SPACE,
        OP_CLEAR,
        OP_READ,
        OP_READ_OOR
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [CHAR_W-1:0]   char_code;
        logic [INDEX_W-1:0]  cell_index;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// File: rtl/tcw_front.sv
// Front end: accepts requests and classifies them into queue entries.
// Depends on tcw_pkg.
module tcw_front #(
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS
) (
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]    cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
    input  tcw_pkg::q_status_t           q_status,
    input  logic                         init_busy,
    output logic                         push,
    output tcw_pkg::entry_t              push_entry
);
    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    assign in_stall = q_status.full || init_busy;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        push_entry.char_code  = char_code;
        push_entry.cell_index = cell_index;
        case (cmd)
            CMD_PUT:
            begin
                if (char_code == CH_NEWLINE)
                    push_entry.op = OP_NEWLINE;
                else if (char_code == CH_SPACE)
                    push_entry.op = OP_SPACE;
                else
                    push_entry.op = OP_CHAR;
            end
            CMD_CLEAR: push_entry.op = OP_CLEAR;
            CMD_READ:
            begin
                // out-of-range reads answer zeros without touching memory
                if (int'(cell_index) < CELLS)
                    push_entry.op = OP_READ;
                else
                    push_entry.op = OP_READ_OOR;
            end
            default: push_entry.op = OP_NOP;
        endcase
    end

endmodule

// File: rtl/tcw_queue.sv
// Short request queue between the front end and the back end.
// Depends on tcw_pkg.
module tcw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcw_pkg::entry_t     push_entry,
    input  logic                pop,
    output tcw_pkg::entry_t     head,
    output tcw_pkg::q_status_t  status
);
    import tcw_pkg::*;

    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    entry_t            slots_reg [QUEUE_DEPTH];
    logic [QW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QW'(1);
        if (push && !pop)
            count_next = count_reg + CNTW'(1);
        else if (pop && !push)
            count_next = count_reg - CNTW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    assign head         = slots_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNTW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

// File: rtl/tcw_back.sv
// Back end: screen memory, cursor, scroll and clear sequencer, result register.
// Depends on tcw_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tcw_back #(
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
    input  tcw_pkg::entry_t               head,
    input  tcw_pkg::q_status_t            q_status,
    output logic                          pop,
    output logic                          init_busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]  cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]    read_char,
    output logic [tcw_pkg::COLOR_W-1:0]   read_color
);
    import tcw_pkg::*;

    localparam int CELLS    = ROWS * COLUMNS;
    localparam int LAST_ROW = CELLS - COLUMNS;
    localparam int AW       = $clog2(CELLS + 1);
    localparam int IW       = $clog2(CELLS);
    localparam int CLW      = $clog2(COLUMNS);

    typedef enum logic [6:0] {
        S_INIT    = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_READ    = 7'b0000100,
        S_COPY    = 7'b0001000,
        S_FILL    = 7'b0010000,
        S_APPLY   = 7'b0100000,
        S_CLEARED = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [CLW-1:0]      col_reg, col_next;
    entry_t              op_reg, op_next;
    logic [IW-1:0]       fill_ptr_reg, fill_ptr_next;
    logic [AW-1:0]       copy_ptr_reg, copy_ptr_next;
    logic                pend_reg, pend_next;
    logic [IW-1:0]       pend_addr_reg, pend_addr_next;
    logic                scroll_reg, scroll_next;
    logic                out_valid_reg, out_valid_next;
    logic [CURSOR_W-1:0] out_cursor_reg, out_cursor_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic [COLOR_W-1:0]  out_color_reg, out_color_next;

    logic [CELL_W-1:0]   screen_mem [CELLS];
    logic [CELL_W-1:0]   rdata_reg;
    logic                we, re;
    logic [IW-1:0]       waddr, raddr;
    logic [CELL_W-1:0]   wdata;

    entry_t              cur_entry;
    logic [AW-1:0]       ap_cursor;
    logic [CLW-1:0]      ap_col;
    logic                ap_we;
    logic                out_free;
    logic                past_end;
    logic                emit;
    logic [AW-1:0]       emit_cursor;
    logic [CHAR_W-1:0]   emit_char;
    logic [COLOR_W-1:0]  emit_color;

    assign out_free  = !out_valid_reg || !out_stall;
    assign past_end  = (cursor_reg >= AW'(CELLS));
    assign cur_entry = (state_reg == S_IDLE) ? head : op_reg;

    // cursor step for a put request; the column counter spares a modulo
    always_comb
    begin
        ap_cursor = cursor_reg + AW'(1);
        ap_col    = (col_reg == CLW'(COLUMNS - 1)) ? '0 : col_reg + CLW'(1);
        ap_we     = (cur_entry.op == OP_CHAR);
        if (cur_entry.op == OP_NEWLINE)
        begin
            ap_cursor = cursor_reg + AW'(COLUMNS) - AW'(col_reg);
            ap_col    = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        col_next       = col_reg;
        op_next        = op_reg;
        fill_ptr_next  = fill_ptr_reg;
        copy_ptr_next  = copy_ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        scroll_next    = scroll_reg;
        pop            = 1'b0;
        we             = 1'b0;
        waddr          = fill_ptr_reg;
        wdata          = {CHAR_W'(0), text_color};
        re             = 1'b0;
        raddr          = copy_ptr_reg[IW-1:0];
        emit           = 1'b0;
        emit_cursor    = cursor_reg;
        emit_char      = '0;
        emit_color     = '0;

        case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                wdata = {CHAR_W'(0), RESET_COLOR};
                if (fill_ptr_reg == IW'(CELLS - 1))
                begin
                    fill_ptr_next = '0;
                    state_next    = S_IDLE;
                end
                else
                    fill_ptr_next = fill_ptr_reg + IW'(1);
            end
            S_IDLE:
            begin
                if (!q_status.empty && out_free)
                begin
                    pop     = 1'b1;
                    op_next = head;
                    case (head.op)
                        OP_READ:
                        begin
                            re         = 1'b1;
                            raddr      = IW'(head.cell_index);
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            fill_ptr_next = '0;
                            scroll_next   = 1'b0;
                            state_next    = S_FILL;
                        end
                        OP_CHAR, OP_NEWLINE, OP_SPACE:
                        begin
                            if (past_end)
                            begin
                                copy_ptr_next = AW'(COLUMNS);
                                pend_next     = 1'b0;
                                state_next    = S_COPY;
                            end
                            else
                            begin
                                we          = ap_we;
                                waddr       = cursor_reg[IW-1:0];
                                wdata       = {head.char_code, text_color};
                                cursor_next = ap_cursor;
                                col_next    = ap_col;
                                emit        = 1'b1;
                                emit_cursor = ap_cursor;
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_char  = rdata_reg[CELL_W-1:COLOR_W];
                    emit_color = rdata_reg[COLOR_W-1:0];
                    state_next = S_IDLE;
                end
            end
            S_COPY:
            begin
                // write back the row below, one cell behind the read
                if (pend_reg)
                begin
                    we    = 1'b1;
                    waddr = pend_addr_reg;
                    wdata = rdata_reg;
                end
                if (copy_ptr_reg < AW'(CELLS))
                begin
                    re             = 1'b1;
                    raddr          = copy_ptr_reg[IW-1:0];
                    copy_ptr_next  = copy_ptr_reg + AW'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = IW'(copy_ptr_reg - AW'(COLUMNS));
                end
                else
                begin
                    pend_next     = 1'b0;
                    fill_ptr_next = IW'(LAST_ROW);
                    scroll_next   = 1'b1;
                    state_next    = S_FILL;
                end
            end
            S_FILL:
            begin
                we = 1'b1;
                if (fill_ptr_reg == IW'(CELLS - 1))
                begin
                    fill_ptr_next = '0;
                    col_next      = '0;
                    if (scroll_reg)
                    begin
                        cursor_next = AW'(LAST_ROW);
                        state_next  = S_APPLY;
                    end
                    else
                    begin
                        cursor_next = '0;
                        state_next  = S_CLEARED;
                    end
                end
                else
                    fill_ptr_next = fill_ptr_reg + IW'(1);
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    we          = ap_we;
                    waddr       = cursor_reg[IW-1:0];
                    wdata       = {op_reg.char_code, text_color};
                    cursor_next = ap_cursor;
                    col_next    = ap_col;
                    emit        = 1'b1;
                    emit_cursor = ap_cursor;
                    state_next  = S_IDLE;
                end
            end
            S_CLEARED:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_cursor_next = out_cursor_reg;
        out_char_next   = out_char_reg;
        out_color_next  = out_color_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_cursor_next = CURSOR_W'(emit_cursor);
            out_char_next   = emit_char;
            out_color_next  = emit_color;
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cursor_reg    <= '0;
            col_reg       <= '0;
            fill_ptr_reg  <= '0;
            pend_reg      <= 1'b0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            fill_ptr_reg  <= fill_ptr_next;
            pend_reg      <= pend_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        copy_ptr_reg   <= copy_ptr_next;
        pend_addr_reg  <= pend_addr_next;
        out_cursor_reg <= out_cursor_next;
        out_char_reg   <= out_char_next;
        out_color_reg  <= out_color_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            screen_mem[waddr] <= wdata;
        if (re)
            rdata_reg <= screen_mem[raddr];
    end

    assign init_busy   = (state_reg == S_INIT);
    assign out_valid   = out_valid_reg;
    assign cursor_cell = out_cursor_reg;
    assign read_char   = out_char_reg;
    assign read_color  = out_color_reg;

    `TCW_ASSERT_ALWAYS(a_init_quiet, (state_reg == S_INIT) |-> (!out_valid_reg && !pop), "result or pop during init sweep")
    `TCW_ASSERT(a_copy_exit, (state_reg == S_COPY) |=> (state_reg == S_COPY || state_reg == S_FILL), "scroll copy left early")
    `TCW_ASSERT(a_end_column, (cursor_reg == AW'(CELLS)) |-> (col_reg == '0), "column out of step with cursor")

endmodule

// File: rtl/text_console_writer_top.sv
// Timing: a put or no-op request passes from the queue through the back end to the registered
// outputs; a read passes through the screen memory's read register as well. With the output
// free the back end takes one put or no-op per cycle; it takes no new request while a read is
// being answered. Clear and a put that scrolls hold the back end for a sweep of the screen
// memory, set by its single write port. Reset: cursor 0, color 7; the screen memory is then
// cleared in a sweep during which in_stall stays high.
module text_console_writer_top #(
    parameter int ROWS    = tcw_pkg::DEF_ROWS,
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcw_pkg::CMD_W-1:0]     cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]  cursor_cell,
    output logic [tcw_pkg::CHAR_W-1:0]    read_char,
    output logic [tcw_pkg::COLOR_W-1:0]   read_color
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] text_color_reg, text_color_next;
    logic               push, pop, init_busy;
    entry_t             push_entry, head;
    q_status_t          q_status;

    assign text_color_next = cfg_we ? cfg_data : text_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_color_reg <= RESET_COLOR;
        else
            text_color_reg <= text_color_next;
    end

    tcw_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .q_status   (q_status),
        .init_busy  (init_busy),
        .push       (push),
        .push_entry (push_entry)
    );

    tcw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    tcw_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_color  (text_color_reg),
        .head        (head),
        .q_status    (q_status),
        .pop         (pop),
        .init_busy   (init_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cursor_cell (cursor_cell),
        .read_char   (read_char),
        .read_color  (read_color)
    );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_writer_top: directed and random console requests.
// Depends on tcw_pkg and the block's RTL; a shadow screen predicts every readout.
module testbench;
    import tcw_pkg::*;

    localparam int COLUMNS        = DEF_COLUMNS;
    localparam int ROWS           = DEF_ROWS;
    localparam int TOTAL_CELLS    = ROWS * COLUMNS;
    localparam int SETTLE_CYCLES  = TOTAL_CELLS + 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_OFF       = 400;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 128;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CURSOR_W-1:0] cursor;
        logic [CHAR_W-1:0]   code;
        logic [COLOR_W-1:0]  color;
    } readout_t;

    // Shadow copy of the screen; predicts the readout of each accepted request.
    class screen_tracker;
        logic [CHAR_W-1:0]  cell_code  [TOTAL_CELLS];
        logic [COLOR_W-1:0] cell_color [TOTAL_CELLS];
        int unsigned        cursor;
        logic [COLOR_W-1:0] text_color;
        readout_t           due_readouts[$];
        int                 errors;
        int                 n_requests, n_reads, n_clears, n_scrolls, n_checked;

        function new();
            text_color = RESET_COLOR;
            fill_screen(0, TOTAL_CELLS);
            cursor = 0;
            errors = 0;
            n_requests = 0;
            n_reads = 0;
            n_clears = 0;
            n_scrolls = 0;
            n_checked = 0;
        endfunction

        function void fill_screen(int from, int upto);
            for (int i = from; i < upto; i++)
            begin
                cell_code[i]  = '0;
                cell_color[i] = text_color;
            end
        endfunction

        function void set_color(logic [COLOR_W-1:0] c);
            text_color = c;
        endfunction

        function int pending();
            return due_readouts.size();
        endfunction

        function void note_request(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
                                   logic [INDEX_W-1:0] idx);
            readout_t r;
            r.code  = '0;
            r.color = '0;
            n_requests++;
            if (op == CMD_PUT)
            begin
                // scroll first when the cursor sits past the last cell
                if (cursor >= TOTAL_CELLS)
                begin
                    for (int i = 0; i < TOTAL_CELLS - COLUMNS; i++)
                    begin
                        cell_code[i]  = cell_code[i + COLUMNS];
                        cell_color[i] = cell_color[i + COLUMNS];
                    end
                    fill_screen(TOTAL_CELLS - COLUMNS, TOTAL_CELLS);
                    cursor = TOTAL_CELLS - COLUMNS;
                    n_scrolls++;
                end
                if (ch == CH_NEWLINE)
                    cursor = cursor + COLUMNS - (cursor % COLUMNS);
                else if (ch == CH_SPACE)
                    cursor++;
                else
                begin
                    cell_code[cursor]  = ch;
                    cell_color[cursor] = text_color;
                    cursor++;
                end
            end
            else if (op == CMD_CLEAR)
            begin
                fill_screen(0, TOTAL_CELLS);
                cursor = 0;
                n_clears++;
            end
            else if (op == CMD_READ)
            begin
                n_reads++;
                if (idx < TOTAL_CELLS)
                begin
                    r.code  = cell_code[idx];
                    r.color = cell_color[idx];
                end
            end
            r.cursor = cursor[CURSOR_W-1:0];
            due_readouts.push_back(r);
        endfunction

        function void check_readout(logic [CURSOR_W-1:0] cur, logic [CHAR_W-1:0] code,
                                    logic [COLOR_W-1:0] color);
            readout_t want;
            if (due_readouts.size() == 0)
            begin
                $error("readout with none pending: cursor_cell %0d read_char %0d read_color %0d",
                       cur, code, color);
                errors++;
                return;
            end
            want = due_readouts.pop_front();
            n_checked++;
            if (cur !== want.cursor)
            begin
                $error("cursor_cell: expected %0d, got %0d", want.cursor, cur);
                errors++;
            end
            if (code !== want.code)
            begin
                $error("read_char: expected %0d, got %0d", want.code, code);
                errors++;
            end
            if (color !== want.color)
            begin
                $error("read_color: expected %0d, got %0d", want.color, color);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [COLOR_W-1:0]  cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
    logic                out_valid;
    logic                out_stall;
    logic [CURSOR_W-1:0] cursor_cell;
    logic [CHAR_W-1:0]   read_char;
    logic [COLOR_W-1:0]  read_color;

    screen_tracker board;
    bit            sender_gaps;
    bit            receiver_gaps;
    bit            hold_off_req;

    text_console_writer_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_cell(cursor_cell),
        .read_char  (read_char),
        .read_color (read_color)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offer one request and return at the edge where it is taken.
    task automatic send_request(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                input logic [INDEX_W-1:0] idx);
        while (sender_gaps && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        char_code  <= ch;
        cell_index <= idx;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
                break;
            @(posedge clk);
        end
        @(posedge clk);
        board.note_request(op, ch, idx);
    endtask

    // Hold the sender until every readout is back; optionally let a fill sweep finish too.
    task automatic drain(input bit settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
        if (settle)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] c);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_color(c);
    endtask

    task automatic send_random(input int newline_pct, input int clear_pct);
        int                 pick;
        int                 back;
        int unsigned        spot;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        pick = $urandom_range(99);
        ch   = CHAR_W'($urandom_range(255));
        idx  = INDEX_W'($urandom_range(2 ** INDEX_W - 1));
        if (pick < 72)
        begin
            back = $urandom_range(99);
            if (back < newline_pct)
                ch = CH_NEWLINE;
            else if (back < newline_pct + 8)
                ch = CH_SPACE;
            send_request(CMD_PUT, ch, idx);
        end
        else if (pick < 90)
        begin
            back = $urandom_range(9);
            // half the time look just behind the cursor, where fresh writes and scrolled rows are
            if (back < 5)
            begin
                spot = board.cursor;
                back = $urandom_range(COLUMNS + 1);
                idx  = INDEX_W'((spot > back) ? spot - back : 0);
            end
            else if (back < 9)
                idx = INDEX_W'($urandom_range(TOTAL_CELLS - 1));
            else
                idx = INDEX_W'($urandom_range(2 ** INDEX_W - 1, TOTAL_CELLS));
            send_request(CMD_READ, ch, idx);
        end
        else if (pick < 90 + clear_pct)
            send_request(CMD_CLEAR, ch, idx);
        else if (pick < 96)
            send_request(CMD_UNUSED, ch, idx);
        else
            send_request(CMD_W'($urandom_range(3)), ch, idx);
    endtask

    // Receiver: random stall, plus one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_OFF) @(posedge clk);
            end
            out_stall <= receiver_gaps && ($urandom_range(99) < 36);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_readout(cursor_cell, read_char, read_color);
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        logic [COLOR_W-1:0] color_plan [PHASES];
        int                 newline_pct;
        int                 clear_pct;
        board         = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        cmd           = CMD_PUT;
        char_code     = '0;
        cell_index    = '0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_off_req  = 1'b0;
        color_plan    = '{4'd15, 4'd0, 4'd9, 4'd15, 4'd0, 4'd3, 4'd15, 4'd0};
        for (int p = 0; p < PHASES; p++)
            if (p % 3 == 2)
                color_plan[p] = COLOR_W'($urandom_range(15));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cells after reset, both ends and out of range
        send_request(CMD_READ, 8'd0, 11'd0);
        send_request(CMD_READ, 8'hff, INDEX_W'(TOTAL_CELLS - 1));
        send_request(CMD_READ, 8'd0, INDEX_W'(TOTAL_CELLS));
        send_request(CMD_READ, 8'hff, 11'h7ff);
        // code 255, code 0, space, ordinary, newline
        send_request(CMD_PUT, 8'hff, 11'h7ff);
        send_request(CMD_PUT, 8'd0, 11'd0);
        send_request(CMD_PUT, CH_SPACE, 11'd0);
        send_request(CMD_PUT, 8'd65, 11'd0);
        send_request(CMD_PUT, CH_NEWLINE, 11'd0);
        for (int i = 0; i < 4; i++)
            send_request(CMD_READ, 8'd0, INDEX_W'(i));
        send_request(CMD_UNUSED, 8'hff, 11'h7ff);
        send_request(CMD_UNUSED, 8'd0, 11'd0);
        drain(1'b1);
        write_color(4'd15);
        send_request(CMD_PUT, 8'd90, 11'd0);
        send_request(CMD_READ, 8'd0, INDEX_W'(COLUMNS));
        send_request(CMD_CLEAR, 8'hff, 11'h7ff);
        send_request(CMD_READ, 8'd0, INDEX_W'(COLUMNS));
        send_request(CMD_READ, 8'd0, INDEX_W'(TOTAL_CELLS - 1));
        send_request(CMD_PUT, CH_NEWLINE, 11'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain(1'b1);
            write_color(color_plan[p]);
            // odd phases run newline-heavy without clears so the screen fills and scrolls
            newline_pct   = (p % 2) ? 35 : 10;
            clear_pct     = (p % 2) ? 0 : 2;
            sender_gaps   = (p != 4);
            receiver_gaps = (p != 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 40)
                    hold_off_req = 1'b1;
                if (p == 5 && n == 60)
                    drain(1'b0);
                send_random(newline_pct, clear_pct);
            end
        end

        drain(1'b0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d reads, %0d clears, %0d scrolls; %0d readouts checked",
                 board.n_requests, board.n_reads, board.n_clears, board.n_scrolls,
                 board.n_checked);
        $display("colors swept over %0d settings including 0 and 15, with stalls and gaps",
                 PHASES + 2);
        if (board.errors == 0 && board.pending() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer_top.sv
tb/testbench.sv
